/* sv/gasa_pkg.sv */
// Shared types and constants of the glyph atlas shelf allocator.
package gasa_pkg;

    localparam int ITEM_W      = 10;
    localparam int PAGE_IDX_W  = 4;
    localparam int COORD_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int GEN_W       = 16;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 2'd2;

    typedef struct packed {
        logic accept;
        logic class_calc;
        logic lookup;
        logic hit_commit;
        logic scan_start;
        logic scan_step;
        logic decide_commit;
        logic sweep_wr;
        logic clear_done;
    } t_dp_cmd;

    typedef struct packed {
        logic in_clear;
        logic shelf_hit;
        logic scan_done;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* sv/gasa_dp.sv */
// Datapath: shelf and page tables, size math, best-fit scan and result register.
module gasa_dp
    import gasa_pkg::*;
#(
    parameter int PAGE_WIDTH  = 256,
    parameter int PAGE_HEIGHT = 256,
    parameter int ROW_GRANULE = 4,
    parameter int MAX_PAGES   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    input  logic                   i_in_user,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    output logic [STATUS_W-1:0]    o_out_user
);

    localparam int SHELF_COUNT = PAGE_HEIGHT / ROW_GRANULE;
    localparam int SIW = (SHELF_COUNT > 1) ? $clog2(SHELF_COUNT) : 1;
    localparam int PIW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCW = $clog2(MAX_PAGES + 1);
    localparam int FW  = $clog2(PAGE_WIDTH + 1);
    localparam int FH  = $clog2(PAGE_HEIGHT + 1);
    localparam int TW  = $clog2((2 ** ITEM_W) + ROW_GRANULE);
    localparam int CW  = $clog2(SHELF_COUNT + 1);
    localparam int RS  = 20;
    localparam int RM  = ((2 ** RS) + ROW_GRANULE - 1) / ROW_GRANULE;
    localparam int RMW = RS + 1;
    localparam int PRW = TW + RMW;

    typedef struct packed {
        logic           valid;
        logic [PIW-1:0] page;
        logic [FW-1:0]  free;
        logic [FH-1:0]  row;
    } t_shelf;

    t_shelf               r_shelf_mem [SHELF_COUNT];
    logic [FH-1:0]        r_page_mem  [MAX_PAGES];

    logic [ITEM_W-1:0]    r_w, r_h;
    logic [FW-1:0]        r_pw;
    logic [TW-1:0]        r_t;
    logic [CW-1:0]        r_cls;
    logic [FH-1:0]        r_rh;
    logic [SIW-1:0]       r_idx;
    t_shelf               r_shelf_rd;
    logic [FH-1:0]        r_pg_rd;
    logic [PIW-1:0]       r_pend_idx;
    logic [PIW-1:0]       r_best;
    logic [FH-1:0]        r_best_fh;
    logic                 r_found;
    logic                 r_pend;
    logic [PCW-1:0]       r_scan_left;
    logic [PCW-1:0]       r_page_count;
    logic [SIW-1:0]       r_sweep;
    logic [GEN_W-1:0]     r_gen;
    logic                 r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0]  r_out_user;

    logic [ITEM_W-1:0]    l_in_w, l_in_h;
    logic [ITEM_W:0]      l_wp;
    logic [FW-1:0]        n_pw;
    logic [TW-1:0]        n_t;
    logic [PRW-1:0]       l_prod;
    logic [SIW-1:0]       l_idx;
    logic                 l_hit;
    logic [FW-1:0]        l_hit_free;
    logic [PIW-1:0]       l_scan_addr;
    logic                 l_better;
    logic                 l_full;
    logic [PIW-1:0]       l_dec_page;
    logic [FH-1:0]        l_dec_fh;
    logic [FH-1:0]        l_new_fh;
    logic [FW-1:0]        l_new_free;
    logic                 l_sh_we;
    logic [SIW-1:0]       l_sh_wa;
    t_shelf               l_sh_wd;
    logic                 l_load;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic [STATUS_W-1:0]  n_out_user;
    logic [GEN_W-1:0]     n_gen;

    function automatic logic [OUT_TDATA_W-1:0] pack_result(
        input logic [PAGE_IDX_W-1:0] page,
        input logic [COORD_W-1:0]    x,
        input logic [COORD_W-1:0]    y,
        input logic [ITEM_W-1:0]     w,
        input logic [ITEM_W-1:0]     h,
        input logic                  opened,
        input logic [GEN_W-1:0]      gen
    );
        pack_result = {7'd0, gen, opened, h, w, y, x, page};
    endfunction

    assign l_in_w = i_in_data[ITEM_W-1:0];
    assign l_in_h = i_in_data[2*ITEM_W-1:ITEM_W];

    always_comb begin
        l_wp = {1'b0, l_in_w} + (ITEM_W+1)'(1);
        if (32'(l_wp) > PAGE_WIDTH) begin
            n_pw = FW'(PAGE_WIDTH);
        end else begin
            n_pw = FW'(l_wp);
        end
        n_t = TW'(l_in_h) + TW'(ROW_GRANULE);
        if (32'(n_t) > PAGE_HEIGHT) begin
            n_t = TW'(PAGE_HEIGHT);
        end
    end

    assign l_prod      = PRW'(r_t) * PRW'(RM);
    assign l_idx       = SIW'(r_cls - CW'(1));
    assign l_hit       = r_shelf_rd.valid && (r_shelf_rd.free >= r_pw);
    assign l_hit_free  = r_shelf_rd.free - r_pw;
    assign l_scan_addr = PIW'(r_scan_left - PCW'(1));
    assign l_better    = (r_pg_rd >= r_rh) && (!r_found || (r_best_fh > r_pg_rd));
    assign l_full      = !r_found && (r_page_count == PCW'(MAX_PAGES));
    assign l_dec_page  = r_found ? r_best : PIW'(r_page_count);
    assign l_dec_fh    = r_found ? r_best_fh : FH'(PAGE_HEIGHT);
    assign l_new_fh    = l_dec_fh - r_rh;
    assign l_new_free  = FW'(PAGE_WIDTH) - r_pw;
    assign n_gen       = r_gen + GEN_W'(1);

    always_comb begin
        l_sh_we = 1'b0;
        l_sh_wa = r_idx;
        l_sh_wd = '0;
        if (i_cmd.sweep_wr) begin
            l_sh_we = 1'b1;
            l_sh_wa = r_sweep;
        end else if (i_cmd.hit_commit) begin
            l_sh_we = 1'b1;
            l_sh_wd = '{valid: 1'b1, page: r_shelf_rd.page, free: l_hit_free,
                        row: r_shelf_rd.row};
        end else if (i_cmd.decide_commit && !l_full) begin
            l_sh_we = 1'b1;
            l_sh_wd = '{valid: 1'b1, page: l_dec_page, free: l_new_free, row: l_new_fh};
        end
    end

    always_comb begin
        l_load     = 1'b1;
        n_out_data = '0;
        n_out_user = ST_ALLOCATED;
        if (i_cmd.hit_commit) begin
            n_out_data = pack_result(PAGE_IDX_W'(r_shelf_rd.page), COORD_W'(l_hit_free),
                                     COORD_W'(r_shelf_rd.row), r_w, r_h, 1'b0, r_gen);
        end else if (i_cmd.decide_commit && l_full) begin
            n_out_data = pack_result('0, '0, '0, r_w, r_h, 1'b0, r_gen);
            n_out_user = ST_NO_PAGE;
        end else if (i_cmd.decide_commit) begin
            n_out_data = pack_result(PAGE_IDX_W'(l_dec_page), COORD_W'(l_new_free),
                                     COORD_W'(l_new_fh), r_w, r_h, !r_found, r_gen);
        end else if (i_cmd.clear_done) begin
            n_out_data = pack_result('0, '0, '0, '0, '0, 1'b0, n_gen);
            n_out_user = ST_CLEARED;
        end else begin
            l_load = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l_sh_we) begin
            r_shelf_mem[l_sh_wa] <= l_sh_wd;
        end
        if (i_cmd.lookup) begin
            r_shelf_rd <= r_shelf_mem[l_idx];
        end
        if (i_cmd.decide_commit && !l_full) begin
            r_page_mem[l_dec_page] <= l_new_fh;
        end
        if (i_cmd.scan_step && (r_scan_left != '0)) begin
            r_pg_rd    <= r_page_mem[l_scan_addr];
            r_pend_idx <= l_scan_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_w  <= l_in_w;
            r_h  <= l_in_h;
            r_pw <= n_pw;
            r_t  <= n_t;
        end
        if (i_cmd.class_calc) begin
            r_cls <= CW'(l_prod >> RS);
        end
        if (i_cmd.lookup) begin
            r_rh  <= FH'(32'(r_cls) * ROW_GRANULE);
            r_idx <= l_idx;
        end
        if (i_cmd.scan_step && r_pend && l_better) begin
            r_best    <= r_pend_idx;
            r_best_fh <= r_pg_rd;
        end
        if (l_load) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= '0;
            r_page_count <= '0;
            r_gen        <= '0;
            r_scan_left  <= '0;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.sweep_wr) begin
                r_sweep <= o_sts.sweep_last ? '0 : r_sweep + SIW'(1);
            end
            if (i_cmd.scan_start) begin
                r_scan_left <= r_page_count;
                r_pend      <= 1'b0;
                r_found     <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_pend <= (r_scan_left != '0);
                if (r_scan_left != '0) begin
                    r_scan_left <= r_scan_left - PCW'(1);
                end
                if (r_pend && l_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.decide_commit && !l_full && !r_found) begin
                r_page_count <= r_page_count + PCW'(1);
            end
            if (i_cmd.clear_done) begin
                r_page_count <= '0;
                r_gen        <= n_gen;
            end
            if (l_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.in_clear   = (i_in_user == REQ_CLEAR);
    assign o_sts.shelf_hit  = l_hit;
    assign o_sts.scan_done  = (r_scan_left == '0) && !r_pend;
    assign o_sts.sweep_last = (r_sweep == SIW'(SHELF_COUNT - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

/* sv/gasa_ctrl.sv */
// Controller: sequences lookup, best-fit scan, commit and shelf clearing sweeps.
module gasa_ctrl
    import gasa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_CLASS,
        S_LOOKUP,
        S_SHELF,
        S_SEARCH,
        S_DECIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_sts.in_clear ? S_CLEAR : S_CLASS;
                end
            end
            S_CLEAR: begin
                if (!i_sts.sweep_last) begin
                    o_cmd.sweep_wr = 1'b1;
                end else if (i_sts.out_free) begin
                    o_cmd.sweep_wr   = 1'b1;
                    o_cmd.clear_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLASS: begin
                o_cmd.class_calc = 1'b1;
                n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = S_SHELF;
            end
            S_SHELF: begin
                if (!i_sts.shelf_hit) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_SEARCH;
                end else if (i_sts.out_free) begin
                    o_cmd.hit_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SEARCH: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.out_free) begin
                    o_cmd.decide_commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_ready;

endmodule

/* sv/glyph_atlas_shelf_allocator_core.sv */
// Top level of the glyph atlas shelf allocator.
// Shelf-packing allocator for fixed-size atlas pages, one request at a time. After reset
// a clearing pass walks the PAGE_HEIGHT/ROW_GRANULE shelf entries before s_axis_tready
// rises. An allocate that fits its row class's open shelf commits from that shelf entry;
// a shelf miss walks the page table one entry per cycle through its single read port
// before it commits. A clear request sweeps the shelf table again. A new request is
// taken while the previous result still waits on m_axis.
module glyph_atlas_shelf_allocator_core
    import gasa_pkg::*;
#(
    parameter int PAGE_WIDTH  = 256,
    parameter int PAGE_HEIGHT = 256,
    parameter int ROW_GRANULE = 4,
    parameter int MAX_PAGES   = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // item_width, item_height, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // page_index, area_x, area_y, area_width, area_height, opened_page, generation, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]    m_axis_tuser
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    gasa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gasa_dp #(
        .PAGE_WIDTH  (PAGE_WIDTH),
        .PAGE_HEIGHT (PAGE_HEIGHT),
        .ROW_GRANULE (ROW_GRANULE),
        .MAX_PAGES   (MAX_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    a_single_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.hit_commit, cmd.decide_commit, cmd.clear_done}))
        else $error("more than one result committed in a cycle");

    a_commit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.hit_commit || cmd.decide_commit || cmd.clear_done) |-> sts.out_free)
        else $error("result committed over a pending transaction");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_ALLOCATED || m_axis_tuser == ST_NO_PAGE ||
                           m_axis_tuser == ST_CLEARED))
        else $error("undefined status code on output");

endmodule
